>>> rtl/dcbd_pkg.sv
package dcbd_pkg;

  // Register map, word index into the APB space
  localparam logic [2:0] RegScoreThr = 3'd0;
  localparam logic [2:0] RegPadLeft  = 3'd1;
  localparam logic [2:0] RegPadTop   = 3'd2;
  localparam logic [2:0] RegInvScale = 3'd3;
  localparam logic [2:0] RegImgW     = 3'd4;
  localparam logic [2:0] RegImgH     = 3'd5;
  localparam logic [2:0] RegClassCnt = 3'd6;

  localparam logic [16:0] ScoreThrRst = 17'd16384;
  localparam logic [30:0] InvScaleRst = 31'd65536;
  localparam logic [13:0] ImgWRst     = 14'd1920;
  localparam logic [13:0] ImgHRst     = 14'd1080;
  localparam logic [10:0] ClassCntRst = 11'd80;

  localparam int MaxClasses    = 1024;
  localparam int MaxCandidates = 65536;

  localparam logic [13:0] ImgLimit = 14'd8192;
  localparam logic [10:0] AttrSat  = 11'd2047;
  localparam logic signed [31:0] BestInit = 32'sh8000_0000;

  // Box pipeline: stages from the row register up to the result register, row register included
  localparam int NumStages = 7;
  localparam int NumLanes  = 4;
  localparam int OutW      = 112;

  typedef struct packed {
    logic [9:0]  class_id;
    logic [30:0] score;
    logic [15:0] cand_idx;
  } side_t;

endpackage

>>> rtl/detector_candidate_box_decode.sv
// Candidate box decoder. Attribute values stream in one per cycle, candidate-major,
// with tlast on the last value of each row: centre x, centre y, width, height, then
// class scores feeding a running argmax (first index wins on ties). A row whose best
// score reaches score_threshold is taken out of letterbox space, truncated toward zero,
// clipped to the frame and, if non-empty, emitted as one result item. One input item is
// taken every cycle while tready is high; a row's result passes through the box pipeline
// (row register, six arithmetic stages with each 35x31 multiply split into two registered
// partial products, result register). While results are held back the pipeline absorbs
// up to eight passing rows before tready drops. Configuration is written through the
// APB port.
module detector_candidate_box_decode (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [31:0]               s_axis_tdata,   // attr_value
  input  logic                      s_axis_tlast,   // row_end
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // box_x[12:0], box_y[25:13], box_w[39:26], box_h[53:40], class_id[63:54],
  // best_score_out[94:64], candidate_index[110:95], zero pad [111]
  output logic [dcbd_pkg::OutW-1:0] m_axis_tdata,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [4:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import dcbd_pkg::*;

  // Configuration registers
  logic [16:0] thr_q;
  logic [11:0] pad_l_q, pad_t_q;
  logic [30:0] inv_q;
  logic [13:0] img_w_q, img_h_q;
  logic [10:0] cls_cnt_q;

  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= ScoreThrRst;
      pad_l_q   <= '0;
      pad_t_q   <= '0;
      inv_q     <= InvScaleRst;
      img_w_q   <= ImgWRst;
      img_h_q   <= ImgHRst;
      cls_cnt_q <= ClassCntRst;
    end else if (cfg_wr) begin
      case (cfg_idx)
        RegScoreThr: thr_q     <= pwdata[16:0];
        RegPadLeft:  pad_l_q   <= pwdata[11:0];
        RegPadTop:   pad_t_q   <= pwdata[11:0];
        RegInvScale: inv_q     <= pwdata[30:0];
        RegImgW:     img_w_q   <= pwdata[13:0];
        RegImgH:     img_h_q   <= pwdata[13:0];
        RegClassCnt: cls_cnt_q <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      RegScoreThr: prdata = {15'b0, thr_q};
      RegPadLeft:  prdata = {20'b0, pad_l_q};
      RegPadTop:   prdata = {20'b0, pad_t_q};
      RegInvScale: prdata = {1'b0, inv_q};
      RegImgW:     prdata = {18'b0, img_w_q};
      RegImgH:     prdata = {18'b0, img_h_q};
      RegClassCnt: prdata = {21'b0, cls_cnt_q};
      default:     prdata = '0;
    endcase
  end

  // Row accumulation
  logic [10:0]        attr_cnt_q;
  logic [15:0]        row_cnt_q;
  logic signed [31:0] best_q;
  logic [9:0]         best_cls_q;
  logic [31:0]        box_q [NumLanes];

  logic               acc;
  logic signed [31:0] attr_v, best_d;
  logic [9:0]         best_cls_d;
  logic [10:0]        cls_pos;
  logic               upd, row_pass;
  logic [31:0]        box_d [NumLanes];
  logic [16:0]        row_nxt;

  assign acc     = s_axis_tvalid & s_axis_tready;
  assign attr_v  = s_axis_tdata;
  assign cls_pos = attr_cnt_q - 11'd4;
  assign upd     = (attr_cnt_q >= 11'd4) && (cls_pos < cls_cnt_q) &&
                   (cls_pos < 11'(MaxClasses)) && (attr_v > best_q);
  assign best_d     = upd ? attr_v : best_q;
  assign best_cls_d = upd ? cls_pos[9:0] : best_cls_q;
  assign row_pass   = acc && s_axis_tlast && (best_d >= $signed({15'b0, thr_q}));
  assign row_nxt    = {1'b0, row_cnt_q} + 17'd1;

  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      box_d[i] = (attr_cnt_q == 11'(i)) ? s_axis_tdata : box_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_cnt_q <= '0;
      row_cnt_q  <= '0;
      best_q     <= BestInit;
      best_cls_q <= '0;
      for (int i = 0; i < NumLanes; i++) box_q[i] <= '0;
    end else if (acc) begin
      for (int i = 0; i < NumLanes; i++) box_q[i] <= box_d[i];
      if (s_axis_tlast) begin
        attr_cnt_q <= '0;
        best_q     <= BestInit;
        best_cls_q <= '0;
        row_cnt_q  <= (row_nxt >= 17'(MaxCandidates)) ? '0 : row_nxt[15:0];
      end else begin
        if (attr_cnt_q < AttrSat) attr_cnt_q <= attr_cnt_q + 11'd1;
        best_q     <= best_d;
        best_cls_q <= best_cls_d;
      end
    end
  end

  // Pipeline control: each stage loads when empty or when the next one moves
  logic [NumStages-1:0] vld_q, ld;
  logic                 out_ld;
  side_t                side_q [NumStages];
  side_t                side_in;

  assign out_ld = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    ld[NumStages-1] = !vld_q[NumStages-1] || out_ld;
    for (int k = NumStages - 2; k >= 0; k--) begin
      ld[k] = !vld_q[k] || ld[k+1];
    end
  end

  assign s_axis_tready = ld[0];

  assign side_in = '{class_id: best_cls_d, score: best_d[30:0], cand_idx: row_cnt_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (ld[0]) vld_q[0] <= row_pass;
      for (int k = 1; k < NumStages; k++) begin
        if (ld[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) side_q[0] <= side_in;
    for (int k = 1; k < NumStages; k++) begin
      if (ld[k]) side_q[k] <= side_q[k-1];
    end
  end

  // Box arithmetic, four lanes: left, top, width, height
  logic [31:0] row_box_q [NumLanes];
  logic [35:0] lin_q     [NumLanes];
  logic        neg2_q    [NumLanes];
  logic [34:0] mag_q     [NumLanes];
  logic        neg3_q    [NumLanes];
  logic [47:0] ph_q      [NumLanes];
  logic [48:0] pl_q      [NumLanes];
  logic        neg4_q    [NumLanes];
  logic [34:0] quo_q     [NumLanes];
  logic [35:0] sv_q      [NumLanes];
  logic [36:0] x1_q, x2_q, y1_q, y2_q;

  logic [35:0] lin_d [NumLanes];
  logic [35:0] neg_lin [NumLanes];
  logic [65:0] prod [NumLanes];
  logic [36:0] left_e, top_e, wid_e, hgt_e, re_x, re_y, iw_e, ih_e;
  logic [13:0] iw, ih;
  logic [36:0] dx, dy;
  logic        nonempty;

  always_comb begin
    lin_d[0] = {{3{row_box_q[0][31]}}, row_box_q[0], 1'b0}
             - {{4{row_box_q[2][31]}}, row_box_q[2]}
             - {7'b0, pad_l_q, 17'b0};
    lin_d[1] = {{3{row_box_q[1][31]}}, row_box_q[1], 1'b0}
             - {{4{row_box_q[3][31]}}, row_box_q[3]}
             - {7'b0, pad_t_q, 17'b0};
    lin_d[2] = {{4{row_box_q[2][31]}}, row_box_q[2]};
    lin_d[3] = {{4{row_box_q[3][31]}}, row_box_q[3]};
    for (int i = 0; i < NumLanes; i++) begin
      neg_lin[i] = 36'd0 - lin_q[i];
      prod[i]    = {ph_q[i], 18'b0} + 66'(pl_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NumLanes; i++) begin
      if (ld[0]) row_box_q[i] <= box_d[i];
      if (ld[1]) lin_q[i] <= lin_d[i];
      if (ld[2]) begin
        neg2_q[i] <= lin_q[i][35];
        mag_q[i]  <= lin_q[i][35] ? neg_lin[i][34:0] : lin_q[i][34:0];
      end
      // Split the magnitude so each product stays within 18x31
      if (ld[3]) begin
        neg3_q[i] <= neg2_q[i];
        ph_q[i]   <= {31'b0, mag_q[i][34:18]} * {17'b0, inv_q};
        pl_q[i]   <= {31'b0, mag_q[i][17:0]} * {18'b0, inv_q};
      end
      // Edges are in 2^-33 units, sizes in 2^-32 units
      if (ld[4]) begin
        neg4_q[i] <= neg3_q[i];
        quo_q[i]  <= (i < 2) ? 35'(prod[i] >> 33) : 35'(prod[i] >> 32);
      end
      if (ld[5]) sv_q[i] <= neg4_q[i] ? 36'd0 - {1'b0, quo_q[i]} : {1'b0, quo_q[i]};
    end
  end

  assign iw     = (img_w_q > ImgLimit) ? ImgLimit : img_w_q;
  assign ih     = (img_h_q > ImgLimit) ? ImgLimit : img_h_q;
  assign iw_e   = {23'b0, iw};
  assign ih_e   = {23'b0, ih};
  assign left_e = {sv_q[0][35], sv_q[0]};
  assign top_e  = {sv_q[1][35], sv_q[1]};
  assign wid_e  = {sv_q[2][35], sv_q[2]};
  assign hgt_e  = {sv_q[3][35], sv_q[3]};
  assign re_x   = left_e + wid_e;
  assign re_y   = top_e + hgt_e;

  always_ff @(posedge clk_i) begin
    if (ld[6]) begin
      x1_q <= ($signed(left_e) > 0) ? left_e : '0;
      y1_q <= ($signed(top_e) > 0) ? top_e : '0;
      x2_q <= ($signed(re_x) < $signed(iw_e)) ? re_x : iw_e;
      y2_q <= ($signed(re_y) < $signed(ih_e)) ? re_y : ih_e;
    end
  end

  // Clip result and drop empty boxes
  assign dx       = x2_q - x1_q;
  assign dy       = y2_q - y1_q;
  assign nonempty = ($signed(dx) > 0) && ($signed(dy) > 0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_ld) begin
      m_axis_tvalid <= vld_q[NumStages-1] && nonempty;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      m_axis_tdata <= {1'b0, side_q[NumStages-1].cand_idx, side_q[NumStages-1].score,
                       side_q[NumStages-1].class_id, dy[13:0], dx[13:0],
                       y1_q[12:0], x1_q[12:0]};
    end
  end

endmodule
